@@ sv/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define PCF_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define PCF_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

@@ sv/pcf_pkg.sv @@
`default_nettype none
package pcf_pkg;

   localparam logic [1:0] CMD_SIG  = 2'd0;
   localparam logic [1:0] CMD_HDR  = 2'd1;
   localparam logic [1:0] CMD_DATA = 2'd2;

   localparam logic [2:0] KIND_IHDR = 3'd0;
   localparam logic [2:0] KIND_PLTE = 3'd1;
   localparam logic [2:0] KIND_GAMA = 3'd2;
   localparam logic [2:0] KIND_IDAT = 3'd3;
   localparam logic [2:0] KIND_IEND = 3'd4;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_BAD_KIND = 2'd1;
   localparam logic [1:0] ST_NO_CHUNK = 2'd2;

   localparam logic [31:0] CRC_POLY = 32'hEDB88320;
   localparam logic [31:0] CRC_ONES = 32'hFFFFFFFF;

   // Sequencer steps within one operation.
   localparam logic [3:0] STEP_FIRST_NAME = 4'd4;
   localparam logic [3:0] STEP_LAST_NAME  = 4'd7;
   localparam logic [3:0] STEP_LAST_HDR   = 4'd11;
   localparam logic [3:0] STEP_LAST_SIG   = 4'd7;
   localparam logic [3:0] STEP_LAST_DATA  = 4'd4;

   typedef enum logic [1:0] {
      OP_SIG,
      OP_HDR,
      OP_DATA,
      OP_BAD_KIND
   } op_code_type;

   typedef struct packed {
      op_code_type code;
      logic [30:0] length;
      logic [2:0]  kind;
      logic [7:0]  data;
   } op_type;

   typedef struct packed {
      logic   valid;
      op_type op;
   } queue_head_type;

   function automatic logic [7:0] sig_byte(input logic [2:0] idx);
      logic [7:0] b;
      unique case (idx)
         3'd0:    b = 8'd137;
         3'd1:    b = 8'd80;
         3'd2:    b = 8'd78;
         3'd3:    b = 8'd71;
         3'd4:    b = 8'd13;
         3'd5:    b = 8'd10;
         3'd6:    b = 8'd26;
         default: b = 8'd10;
      endcase
      return b;
   endfunction

   function automatic logic [7:0] name_byte(input logic [2:0] kind, input logic [1:0] idx);
      logic [31:0] w;
      unique case (kind)
         KIND_IHDR: w = "IHDR";
         KIND_PLTE: w = "PLTE";
         KIND_GAMA: w = "gAMA";
         KIND_IDAT: w = "IDAT";
         KIND_IEND: w = "IEND";
         default:   w = 32'd0;
      endcase
      return w[8 * (3 - idx) +: 8];
   endfunction

   // One byte of the reflected CRC-32, bit by bit.
   function automatic logic [31:0] crc_fold(input logic [31:0] c, input logic [7:0] b);
      logic [31:0] r;
      r = c ^ {24'd0, b};
      for (int k = 0; k < 8; k++) begin
         r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
      end
      return r;
   endfunction

endpackage
`default_nettype wire

@@ sv/pcf_front.sv @@
`default_nettype none
module pcf_front (
   input  wire logic            push,
   input  wire logic            queue_full,
   input  wire logic [1:0]      command,
   input  wire logic [30:0]     chunk_length,
   input  wire logic [2:0]      chunk_kind,
   input  wire logic [7:0]      data_byte,
   output      logic            enq,
   output      pcf_pkg::op_type enq_op
);
   import pcf_pkg::*;

   logic keep;

   // Unused commands are accepted and dropped here; everything else is queued.
   always_comb begin
      keep                = 1'b1;
      enq_op.length       = chunk_length;
      enq_op.kind         = chunk_kind;
      enq_op.data         = data_byte;
      unique case (command)
         CMD_SIG:  enq_op.code = OP_SIG;
         CMD_HDR:  enq_op.code = (chunk_kind > KIND_IEND) ? OP_BAD_KIND : OP_HDR;
         CMD_DATA: enq_op.code = OP_DATA;
         default: begin
            enq_op.code = OP_SIG;
            keep        = 1'b0;
         end
      endcase
   end

   assign enq = push && !queue_full && keep;

endmodule
`default_nettype wire

@@ sv/pcf_queue.sv @@
`default_nettype none
`include "assert_macros.svh"
module pcf_queue #(
   parameter int DEPTH = 4
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    enq,
   input  wire pcf_pkg::op_type         enq_op,
   input  wire logic                    deq,
   output      logic                    full,
   output      pcf_pkg::queue_head_type head
);
   import pcf_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   op_type             entry_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (enq) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (deq) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (enq && !deq) begin
         count_in = count_ff + 1'b1;
      end else if (deq && !enq) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enq) begin
         entry_ff[wr_ptr_ff] <= enq_op;
      end
   end

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head.valid = (count_ff != '0);
   assign head.op    = entry_ff[rd_ptr_ff];

   `PCF_ASSERT_NOW(a_count_bound, 1'b1, count_ff <= CNT_W'(DEPTH))
   `PCF_ASSERT_NOW(a_no_deq_empty, deq, count_ff != '0)
   `PCF_ASSERT_NOW(a_no_enq_full, enq, count_ff != CNT_W'(DEPTH))

endmodule
`default_nettype wire

@@ sv/pcf_back.sv @@
`default_nettype none
`include "assert_macros.svh"
module pcf_back (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire pcf_pkg::queue_head_type head,
   output      logic                    deq,
   input  wire logic                    pop,
   output      logic                    empty,
   output      logic [7:0]              out_byte,
   output      logic                    run_last,
   output      logic                    chunk_done,
   output      logic [1:0]              status
);
   import pcf_pkg::*;

   logic [3:0]  step_ff, step_in;
   logic [31:0] crc_ff, crc_in;
   logic [30:0] left_ff, left_in;
   logic        open_ff, open_in;

   logic        valid_ff, valid_in;
   logic [7:0]  byte_ff;
   logic        last_ff;
   logic        done_ff;
   logic [1:0]  status_ff;

   logic        fire;
   logic [7:0]  byte_v;
   logic        last_v;
   logic        done_v;
   logic [1:0]  status_v;
   logic [31:0] len32;
   logic [31:0] crc_out;
   logic [1:0]  crc_idx;
   logic [7:0]  name_v;

   assign fire    = head.valid && (!valid_ff || pop);
   assign len32   = {1'b0, head.op.length};
   assign crc_out = crc_ff ^ CRC_ONES;
   assign name_v  = name_byte(head.op.kind, step_ff[1:0]);

   // Byte, flags and status of the current step of the operation at the queue head.
   always_comb begin
      byte_v   = 8'd0;
      last_v   = 1'b0;
      done_v   = 1'b0;
      status_v = ST_OK;
      crc_idx  = step_ff[1:0];
      unique case (head.op.code)
         OP_SIG: begin
            byte_v = sig_byte(step_ff[2:0]);
            last_v = (step_ff == STEP_LAST_SIG);
         end
         OP_BAD_KIND: begin
            status_v = ST_BAD_KIND;
            last_v   = 1'b1;
         end
         OP_HDR: begin
            if (step_ff < STEP_FIRST_NAME) begin
               byte_v = len32[8 * (3 - step_ff[1:0]) +: 8];
            end else if (step_ff <= STEP_LAST_NAME) begin
               byte_v = name_v;
            end else begin
               byte_v = crc_out[8 * (3 - crc_idx) +: 8];
            end
            last_v = ((step_ff == STEP_LAST_NAME) && (head.op.length != '0)) ||
                     (step_ff == STEP_LAST_HDR);
            done_v = (step_ff == STEP_LAST_HDR);
         end
         OP_DATA: begin
            crc_idx = 2'(step_ff - 4'd1);
            if (!open_ff) begin
               status_v = ST_NO_CHUNK;
               last_v   = 1'b1;
            end else if (step_ff == '0) begin
               byte_v = head.op.data;
               last_v = (left_ff != 31'd1);
            end else begin
               byte_v = crc_out[8 * (3 - crc_idx) +: 8];
               last_v = (step_ff == STEP_LAST_DATA);
               done_v = (step_ff == STEP_LAST_DATA);
            end
         end
         default: begin
            last_v = 1'b1;
         end
      endcase
   end

   // Chunk state updates taken when the current step is handed to the output register.
   always_comb begin
      step_in = step_ff;
      crc_in  = crc_ff;
      left_in = left_ff;
      open_in = open_ff;
      if (fire) begin
         step_in = last_v ? '0 : step_ff + 4'd1;
         unique case (head.op.code)
            OP_HDR: begin
               if (step_ff == STEP_FIRST_NAME) begin
                  crc_in = crc_fold(CRC_ONES, name_v);
               end else if ((step_ff > STEP_FIRST_NAME) && (step_ff <= STEP_LAST_NAME)) begin
                  crc_in = crc_fold(crc_ff, name_v);
               end
               if (step_ff == STEP_LAST_NAME) begin
                  left_in = head.op.length;
                  open_in = 1'b1;
               end
            end
            OP_DATA: begin
               if (open_ff && (step_ff == '0)) begin
                  crc_in  = crc_fold(crc_ff, head.op.data);
                  left_in = left_ff - 31'd1;
               end
            end
            default: begin
            end
         endcase
         if (done_v) begin
            crc_in  = CRC_ONES;
            left_in = '0;
            open_in = 1'b0;
         end
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (fire) begin
         valid_in = 1'b1;
      end else if (pop) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= '0;
         crc_ff   <= CRC_ONES;
         left_ff  <= '0;
         open_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         step_ff  <= step_in;
         crc_ff   <= crc_in;
         left_ff  <= left_in;
         open_ff  <= open_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         byte_ff   <= byte_v;
         last_ff   <= last_v;
         done_ff   <= done_v;
         status_ff <= status_v;
      end
   end

   assign deq        = fire && last_v;
   assign empty      = !valid_ff;
   assign out_byte   = byte_ff;
   assign run_last   = last_ff;
   assign chunk_done = done_ff;
   assign status     = status_ff;

   `PCF_ASSERT_NOW(a_step_bound, 1'b1, step_ff <= STEP_LAST_HDR)
   `PCF_ASSERT_NOW(a_done_is_last, valid_ff && done_ff, last_ff && (status_ff == ST_OK))
   `PCF_ASSERT_NOW(a_error_single, valid_ff && (status_ff != ST_OK), last_ff && (byte_ff == 8'd0))
   `PCF_ASSERT_NEXT(a_done_closes, fire && done_v, !open_ff && (crc_ff == CRC_ONES))

endmodule
`default_nettype wire

@@ sv/png_chunk_framer_crc32_core.sv @@
// PNG chunk framer with CRC-32.
// Requests enter through a queue-style port: a request is taken on a clock edge where push
// is high and full is low. Command 0 emits the eight PNG signature bytes, command 1 emits
// a chunk header (four big-endian length bytes, then the four name bytes), command 2
// passes one data byte into the open chunk. After the last counted data byte, or right
// after the header of an empty chunk, the four bytes of the inverted CRC-32 follow.
// Command 3 is taken and dropped without any output.
// Results leave one byte per cycle on the rsp_ ports while empty is low; a byte is taken
// on an edge where pop is high. run_last marks the last byte caused by one request.
// Each request is written into the queue, and its bytes pass through the output register
// before they reach the ports. A data byte or an error yields one output byte; a
// signature yields eight, a header eight, a header of an empty chunk twelve, and the
// data byte that closes a chunk five. The output sequencer emits one byte per cycle
// unless the receiver stalls, and folds each name and data byte into the CRC as it
// emits it. The request queue holds QUEUE_DEPTH requests, so the sender keeps going
// while a long burst drains. When the receiver stalls, the result holds on the ports
// and the queue fills until full rises. Synchronous reset empties the queue and the
// result register, closes any open chunk and sets the CRC to all ones.
`default_nettype none
module png_chunk_framer_crc32_core #(
   parameter int QUEUE_DEPTH = 4
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   output      logic        full,
   input  wire logic [1:0]  req_command,
   input  wire logic [30:0] req_chunk_length,
   input  wire logic [2:0]  req_chunk_kind,
   input  wire logic [7:0]  req_data_byte,
   output      logic        empty,
   input  wire logic        pop,
   output      logic [7:0]  rsp_out_byte,
   output      logic        rsp_run_last,
   output      logic        rsp_chunk_done,
   output      logic [1:0]  rsp_status
);
   import pcf_pkg::*;

   logic           enq;
   op_type         enq_op;
   logic           deq;
   queue_head_type head;

   // Front end: decodes the command and marks bad chunk kinds before queueing.
   pcf_front u_front (
      .push         (push),
      .queue_full   (full),
      .command      (req_command),
      .chunk_length (req_chunk_length),
      .chunk_kind   (req_chunk_kind),
      .data_byte    (req_data_byte),
      .enq          (enq),
      .enq_op       (enq_op)
   );

   // The queue lets the front keep taking requests while the back end emits a burst.
   pcf_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock  (clock),
      .reset  (reset),
      .enq    (enq),
      .enq_op (enq_op),
      .deq    (deq),
      .full   (full),
      .head   (head)
   );

   // Back end: steps through the bytes of each queued operation and keeps the chunk
   // state (CRC, remaining length, open flag).
   pcf_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .deq        (deq),
      .pop        (pop),
      .empty      (empty),
      .out_byte   (rsp_out_byte),
      .run_last   (rsp_run_last),
      .chunk_done (rsp_chunk_done),
      .status     (rsp_status)
   );

endmodule
`default_nettype wire
